// ===== sv/lzwve_pkg.sv =====
package lzwve_pkg;

  localparam int MAX_CODE_BITS  = 12;
  localparam int CODE_BITS      = 12;
  localparam int BYTE_BITS      = 8;
  localparam int TRIE_ADDR_BITS = CODE_BITS + BYTE_BITS;
  localparam int GEN_BITS       = 16;
  localparam int NEXT_BITS      = 13;
  localparam int LEN_BITS       = 4;
  localparam int LIT_BITS       = 9;
  localparam int RSV_BITS       = 5;
  localparam int CNT_BITS       = 6;
  localparam int BUF_BITS       = 32;
  localparam int PADDR_BITS     = 5;
  localparam int PDATA_BITS     = 32;

  localparam logic [LEN_BITS-1:0]  INIT_LEN_RST   = 4'd9;
  localparam logic [LEN_BITS-1:0]  MAX_LEN_RST    = 4'd12;
  localparam logic [LIT_BITS-1:0]  LIT_COUNT_RST  = 9'd256;
  localparam logic [RSV_BITS-1:0]  RSV_COUNT_RST  = 5'd2;
  localparam logic [CODE_BITS-1:0] RESET_CODE_RST = 12'd256;
  localparam logic [CODE_BITS-1:0] END_CODE_RST   = 12'd257;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    REG_INIT_LEN,
    REG_MAX_LEN,
    REG_LIT_COUNT,
    REG_RSV_COUNT,
    REG_RESET_CODE,
    REG_END_CODE
  } reg_idx_t;

  typedef struct packed {
    logic                 kind;
    logic [BYTE_BITS-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]  initial_code_length;
    logic [LEN_BITS-1:0]  max_code_length;
    logic [LIT_BITS-1:0]  literal_count;
    logic [RSV_BITS-1:0]  reserved_count;
    logic [CODE_BITS-1:0] reset_code;
    logic [CODE_BITS-1:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic [GEN_BITS-1:0]  tag;
    logic [CODE_BITS-1:0] code;
  } trie_entry_t;

  typedef struct packed {
    logic                      rd_en;
    logic [TRIE_ADDR_BITS-1:0] rd_addr;
    logic                      wr_en;
    logic [TRIE_ADDR_BITS-1:0] wr_addr;
    trie_entry_t               wr_data;
    logic                      clear_start;
  } trie_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 use0;
    logic                 use1;
    logic                 pad;
    logic [LEN_BITS-1:0]  width;
    logic [CODE_BITS-1:0] code0;
    logic [CODE_BITS-1:0] code1;
  } emit_req_t;

  function automatic logic [LEN_BITS-1:0] clamp_width(input logic [LEN_BITS-1:0] w);
    logic [LEN_BITS-1:0] r;
    r = w;
    if (w < 4'd2) r = 4'd2;
    else if (w > LEN_BITS'(MAX_CODE_BITS)) r = LEN_BITS'(MAX_CODE_BITS);
    return r;
  endfunction

endpackage

// ===== sv/lzwve_regs.sv =====
module lzwve_regs
  import lzwve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_code_length <= INIT_LEN_RST;
      cfg.max_code_length     <= MAX_LEN_RST;
      cfg.literal_count       <= LIT_COUNT_RST;
      cfg.reserved_count      <= RSV_COUNT_RST;
      cfg.reset_code          <= RESET_CODE_RST;
      cfg.end_code            <= END_CODE_RST;
    end else if (wr) begin
      case (idx)
        REG_INIT_LEN:   cfg.initial_code_length <= pwdata[LEN_BITS-1:0];
        REG_MAX_LEN:    cfg.max_code_length     <= pwdata[LEN_BITS-1:0];
        REG_LIT_COUNT:  cfg.literal_count       <= pwdata[LIT_BITS-1:0];
        REG_RSV_COUNT:  cfg.reserved_count      <= pwdata[RSV_BITS-1:0];
        REG_RESET_CODE: cfg.reset_code          <= pwdata[CODE_BITS-1:0];
        REG_END_CODE:   cfg.end_code            <= pwdata[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INIT_LEN:   prdata = PDATA_BITS'(cfg.initial_code_length);
      REG_MAX_LEN:    prdata = PDATA_BITS'(cfg.max_code_length);
      REG_LIT_COUNT:  prdata = PDATA_BITS'(cfg.literal_count);
      REG_RSV_COUNT:  prdata = PDATA_BITS'(cfg.reserved_count);
      REG_RESET_CODE: prdata = PDATA_BITS'(cfg.reset_code);
      REG_END_CODE:   prdata = PDATA_BITS'(cfg.end_code);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/lzwve_trie.sv =====
module lzwve_trie
  import lzwve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  trie_req_t   req,
  output trie_entry_t rd_data,
  output logic        clearing
);

  trie_entry_t               mem [2**TRIE_ADDR_BITS];
  logic [TRIE_ADDR_BITS-1:0] clr_addr;

  // sweep every entry to zero after reset and on a tag wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (req.clear_start) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end

endmodule

// ===== sv/lzwve_packer.sv =====
module lzwve_packer
  import lzwve_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_req_t emit,
  output logic      ready,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  logic [BUF_BITS-1:0]  bits;
  logic [CNT_BITS-1:0]  cnt;
  logic [BUF_BITS-1:0]  bits_next;
  logic [CNT_BITS-1:0]  cnt_next;
  logic [CNT_BITS-1:0]  cnt1;
  logic [CNT_BITS-1:0]  cnt2;
  logic [CNT_BITS-1:0]  cnt_pad;
  logic [CODE_BITS-1:0] mask;
  logic [BUF_BITS-1:0]  s1;

  assign ready         = cnt < CNT_BITS'(8);
  assign result_valid  = !ready;
  assign result.out_byte = bits[BYTE_BITS-1:0];
  assign result.last   = cnt < CNT_BITS'(16);

  always_comb begin
    mask      = CODE_BITS'((13'd1 << emit.width) - 13'd1);
    s1        = bits;
    cnt1      = cnt;
    if (emit.use0) begin
      s1   = bits | (BUF_BITS'(emit.code0 & mask) << cnt);
      cnt1 = cnt + CNT_BITS'(emit.width);
    end
    bits_next = s1;
    cnt2      = cnt1;
    if (emit.use1) begin
      bits_next = s1 | (BUF_BITS'(emit.code1 & mask) << cnt1);
      cnt2      = cnt1 + CNT_BITS'(emit.width);
    end
    // round up to a whole byte; the bits above are already zero
    cnt_pad  = cnt2 + CNT_BITS'(7);
    cnt_next = emit.pad ? {cnt_pad[CNT_BITS-1:3], 3'b000} : cnt2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      cnt  <= '0;
    end else if (emit.valid) begin
      bits <= bits_next;
      cnt  <= cnt_next;
    end else if (result_valid && !result_stall) begin
      bits <= bits >> BYTE_BITS;
      cnt  <= cnt - CNT_BITS'(8);
    end
  end

endmodule

// ===== sv/lzw_variable_width_encoder_core.sv =====
// Latency: a request resolves once its trie read has returned and the packer holds no whole
//   byte; its first output byte is offered in the cycle after it resolves.
// Throughput: a request is taken only once the last has resolved, as the trie read keyed by
//   the current prefix must return before the next request can form its address; output
//   runs one byte per cycle unless stalled, so multi-byte requests are paced by the output.
// Reset: synchronous, active high. Afterwards every trie entry is swept to zero with
//   item_stall high; the same sweep runs after every 65535th dictionary clear.
module lzw_variable_width_encoder_core
  import lzwve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  trie_req_t   treq;
  trie_entry_t rd_data;
  logic        clearing;
  emit_req_t   emit;
  logic        pk_ready;

  // dictionary walk state
  logic [CODE_BITS-1:0]      prefix_code, prefix_code_next;
  logic                      prefix_valid, prefix_valid_next;
  logic [NEXT_BITS-1:0]      next_code, next_code_next;
  logic [LEN_BITS-1:0]       code_width, code_width_next;
  logic [GEN_BITS-1:0]       gen, gen_next;

  // request held from its trie read until it resolves
  logic                      pend;
  item_t                     pend_item;
  logic [TRIE_ADDR_BITS-1:0] pend_addr;

  logic                      accept;
  logic                      resolve;
  logic                      hit;
  logic                      do_clear;
  logic [NEXT_BITS-1:0]      nc1;

  lzwve_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lzwve_trie u_trie (
    .clk      (clk),
    .rst      (rst),
    .req      (treq),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  lzwve_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .ready        (pk_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Hold off new requests while one is pending or the sweep runs.
  assign item_stall = pend || clearing;
  assign accept     = item_valid && !item_stall;
  // Resolve only once every whole byte of the previous request has left the packer.
  assign resolve    = pend && pk_ready;
  assign hit        = (rd_data.tag == gen) && (rd_data.code != '0);
  assign nc1        = next_code + 1'b1;

  always_comb begin
    prefix_code_next  = prefix_code;
    prefix_valid_next = prefix_valid;
    next_code_next    = next_code;
    code_width_next   = code_width;
    gen_next          = gen;
    do_clear          = 1'b0;

    emit       = '0;
    emit.valid = resolve;
    emit.width = code_width;
    emit.code0 = prefix_code;

    treq             = '0;
    treq.rd_en       = accept;
    treq.rd_addr     = {prefix_code, item.data_byte};
    treq.wr_addr     = pend_addr;
    treq.wr_data.tag = gen;
    treq.wr_data.code = next_code[CODE_BITS-1:0];

    if (resolve) begin
      if (pend_item.kind == KIND_DATA) begin
        if (!prefix_valid) begin
          // first byte of a stream just becomes the prefix
          prefix_code_next  = CODE_BITS'(pend_item.data_byte);
          prefix_valid_next = 1'b1;
        end else if (hit) begin
          prefix_code_next = rd_data.code;
        end else begin
          // miss: emit prefix, add the new code, restart at this byte
          emit.use0        = 1'b1;
          treq.wr_en       = 1'b1;
          prefix_code_next = CODE_BITS'(pend_item.data_byte);
          next_code_next   = nc1;
          if ({1'b0, nc1} > ((NEXT_BITS + 1)'(1) << code_width)) begin
            if (code_width < clamp_width(cfg.max_code_length)) begin
              code_width_next = code_width + 1'b1;
            end else begin
              emit.use1  = 1'b1;
              emit.code1 = cfg.reset_code;
              do_clear   = 1'b1;
            end
          end
        end
      end else begin
        // finish: drain prefix and end code, pad, return to start
        emit.use0         = prefix_valid;
        emit.use1         = cfg.end_code != '0;
        emit.code1        = cfg.end_code;
        emit.pad          = 1'b1;
        prefix_code_next  = '0;
        prefix_valid_next = 1'b0;
        do_clear          = 1'b1;
      end
    end

    if (do_clear) begin
      next_code_next  = NEXT_BITS'(cfg.literal_count) + NEXT_BITS'(cfg.reserved_count);
      code_width_next = clamp_width(cfg.initial_code_length);
      // advance the tag; on wrap sweep the trie and restart at one
      if (gen == '1) begin
        gen_next         = GEN_BITS'(1);
        treq.clear_start = 1'b1;
      end else begin
        gen_next = gen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      next_code    <= NEXT_BITS'(LIT_COUNT_RST) + NEXT_BITS'(RSV_COUNT_RST);
      code_width   <= clamp_width(INIT_LEN_RST);
      gen          <= GEN_BITS'(1);
      pend         <= 1'b0;
    end else begin
      prefix_code  <= prefix_code_next;
      prefix_valid <= prefix_valid_next;
      next_code    <= next_code_next;
      code_width   <= code_width_next;
      gen          <= gen_next;
      if (accept) pend <= 1'b1;
      else if (resolve) pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_item <= item;
      pend_addr <= {prefix_code, item.data_byte};
    end
  end

  // Code width always lies inside the legal range.
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= 4'd2 && code_width <= LEN_BITS'(MAX_CODE_BITS))
    else $error("code width out of range");

  // A finish leaves the encoder with no prefix.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (resolve && pend_item.kind == KIND_FINISH) |=> !prefix_valid)
    else $error("prefix still valid after finish");

  // No dictionary update may collide with the clearing sweep.
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    treq.wr_en |-> !clearing)
    else $error("trie write during sweep");

  // A request resolves only with the packer empty of whole bytes.
  a_resolve_empty: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> !result_valid)
    else $error("emit while bytes pending");

endmodule

// ===== tb/lzwve_scoreboard.sv =====
module lzwve_scoreboard
  import lzwve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  input  logic [PDATA_BITS-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the register file and of the encoder state.
  cfg_t                 regs;
  logic [CODE_BITS-1:0] pfx;
  logic                 pfx_ok;
  logic [NEXT_BITS-1:0] nxt;
  logic [LEN_BITS-1:0]  cw;
  logic [BUF_BITS-1:0]  bitbuf;
  logic [CNT_BITS-1:0]  nbits;
  logic [CODE_BITS-1:0] dict [int];

  result_t              byte_q [$];
  logic [BYTE_BITS-1:0] fresh [$];
  int                   fails = 0;

  function automatic logic [LEN_BITS-1:0] bound_width(input logic [LEN_BITS-1:0] w);
    return (w < 4'd2) ? 4'd2 :
           (w > LEN_BITS'(MAX_CODE_BITS)) ? LEN_BITS'(MAX_CODE_BITS) : w;
  endfunction

  function automatic logic [PDATA_BITS-1:0] reg_value(input logic [2:0] idx);
    case (reg_idx_t'(idx))
      REG_INIT_LEN:   return PDATA_BITS'(regs.initial_code_length);
      REG_MAX_LEN:    return PDATA_BITS'(regs.max_code_length);
      REG_LIT_COUNT:  return PDATA_BITS'(regs.literal_count);
      REG_RSV_COUNT:  return PDATA_BITS'(regs.reserved_count);
      REG_RESET_CODE: return PDATA_BITS'(regs.reset_code);
      REG_END_CODE:   return PDATA_BITS'(regs.end_code);
      default:        return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_BITS-1:0] data);
    case (reg_idx_t'(idx))
      REG_INIT_LEN:   regs.initial_code_length = data[LEN_BITS-1:0];
      REG_MAX_LEN:    regs.max_code_length     = data[LEN_BITS-1:0];
      REG_LIT_COUNT:  regs.literal_count       = data[LIT_BITS-1:0];
      REG_RSV_COUNT:  regs.reserved_count      = data[RSV_BITS-1:0];
      REG_RESET_CODE: regs.reset_code          = data[CODE_BITS-1:0];
      REG_END_CODE:   regs.end_code            = data[CODE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Append a code at the current width, LSB first.
  task automatic pack_code(input logic [CODE_BITS-1:0] code);
    logic [BUF_BITS-1:0] mask;
    mask   = (BUF_BITS'(1) << cw) - BUF_BITS'(1);
    bitbuf = bitbuf | ((BUF_BITS'(code) & mask) << nbits);
    nbits  = nbits + CNT_BITS'(cw);
  endtask

  task automatic take_bytes();
    while (nbits >= CNT_BITS'(8) && fresh.size() < 4) begin
      fresh.push_back(bitbuf[BYTE_BITS-1:0]);
      bitbuf = bitbuf >> 8;
      nbits  = nbits - CNT_BITS'(8);
    end
  endtask

  task automatic restart_dict();
    dict.delete();
    nxt = NEXT_BITS'(regs.literal_count) + NEXT_BITS'(regs.reserved_count);
    cw  = bound_width(regs.initial_code_length);
  endtask

  task automatic predict_bytes(input item_t it);
    int      key;
    result_t r;
    fresh.delete();
    if (it.kind == KIND_DATA) begin
      if (!pfx_ok) begin
        pfx    = CODE_BITS'(it.data_byte);
        pfx_ok = 1'b1;
      end else begin
        key = int'({pfx, it.data_byte});
        if (dict.exists(key) && dict[key] != '0) begin
          pfx = dict[key];
        end else begin
          pack_code(pfx);
          dict[key] = nxt[CODE_BITS-1:0];
          nxt       = nxt + 1'b1;
          pfx       = CODE_BITS'(it.data_byte);
          if (32'(nxt) > (32'd1 << cw)) begin
            if (cw < bound_width(regs.max_code_length)) begin
              cw = cw + 1'b1;
            end else begin
              pack_code(regs.reset_code);
              restart_dict();
            end
          end
        end
      end
      take_bytes();
    end else begin
      if (pfx_ok) pack_code(pfx);
      if (regs.end_code != '0) pack_code(regs.end_code);
      take_bytes();
      if (nbits != '0 && fresh.size() < 4) fresh.push_back(bitbuf[BYTE_BITS-1:0]);
      bitbuf = '0;
      nbits  = '0;
      pfx    = '0;
      pfx_ok = 1'b0;
      restart_dict();
    end
    foreach (fresh[i]) begin
      r.out_byte = fresh[i];
      r.last     = (i == fresh.size() - 1);
      byte_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs.initial_code_length = INIT_LEN_RST;
      regs.max_code_length     = MAX_LEN_RST;
      regs.literal_count       = LIT_COUNT_RST;
      regs.reserved_count      = RSV_COUNT_RST;
      regs.reset_code          = RESET_CODE_RST;
      regs.end_code            = END_CODE_RST;
      pfx    = '0;
      pfx_ok = 1'b0;
      bitbuf = '0;
      nbits  = '0;
      restart_dict();
      byte_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_reg(paddr[4:2], pwdata);
        end else if (prdata !== reg_value(paddr[4:2])) begin
          fails++;
          $display("%0t: register %0d read: expected %h, actual %h",
                   $time, paddr[4:2], reg_value(paddr[4:2]), prdata);
        end
      end
      if (item_valid && !item_stall) predict_bytes(item);
      if (result_valid && !result_stall) begin
        if (byte_q.size() == 0) begin
          fails++;
          $display("%0t: output byte with none expected: expected none, actual %h/%b",
                   $time, result.out_byte, result.last);
        end else begin
          want = byte_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            fails++;
            $display("%0t: out_byte: expected %h, actual %h",
                     $time, want.out_byte, result.out_byte);
          end
          if (result.last !== want.last) begin
            fails++;
            $display("%0t: last: expected %b, actual %b", $time, want.last, result.last);
          end
        end
      end
    end
    fail_count    <= fails;
    expected_left <= byte_q.size();
  end

endmodule

// ===== tb/lzw_variable_width_encoder_core_tb.sv =====
module lzw_variable_width_encoder_core_tb;
  import lzwve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  int fail_count;
  int expected_left;

  // calm: no gaps on either side; hold_req: ask the receiver for one long hold-off
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  lzw_variable_width_encoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  lzwve_scoreboard u_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Valid stays high into the next request when no gap follows.
  task automatic send_item(input logic k, input logic [BYTE_BITS-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {k, b};
    do @(posedge clk); while (item_stall);
  endtask

  // Drop valid, then wait until every expected byte is out. The first edge is
  // skipped since the scoreboard count is registered. The tail covers
  // requests that give no bytes but may still be in flight.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then an idle cycle so psel is never assigned twice in a step.
  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [PDATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Fill the bits above a register field with random junk; the block must drop them.
  function automatic logic [PDATA_BITS-1:0] with_noise(input int w, input logic [PDATA_BITS-1:0] v);
    return (PDATA_BITS'($urandom()) << w) | v;
  endfunction

  // Write all six registers, then read every one back.
  task automatic set_config(input logic [LEN_BITS-1:0] init_len, input logic [LEN_BITS-1:0] max_len,
                            input logic [LIT_BITS-1:0] lit, input logic [RSV_BITS-1:0] rsv,
                            input logic [CODE_BITS-1:0] rst_code,
                            input logic [CODE_BITS-1:0] end_code);
    apb_access(1'b1, REG_INIT_LEN,   with_noise(LEN_BITS, PDATA_BITS'(init_len)));
    apb_access(1'b1, REG_MAX_LEN,    with_noise(LEN_BITS, PDATA_BITS'(max_len)));
    apb_access(1'b1, REG_LIT_COUNT,  with_noise(LIT_BITS, PDATA_BITS'(lit)));
    apb_access(1'b1, REG_RSV_COUNT,  with_noise(RSV_BITS, PDATA_BITS'(rsv)));
    apb_access(1'b1, REG_RESET_CODE, with_noise(CODE_BITS, PDATA_BITS'(rst_code)));
    apb_access(1'b1, REG_END_CODE,   with_noise(CODE_BITS, PDATA_BITS'(end_code)));
    for (int i = 0; i < 6; i++) apb_access(1'b0, reg_idx_t'(i), '0);
  endtask

  // Random settings, leaning to small widths so dictionary resets come often,
  // with the field extremes mixed in.
  task automatic random_config();
    int                   r;
    logic [LEN_BITS-1:0]  lens [2];
    logic [LIT_BITS-1:0]  lit;
    logic [RSV_BITS-1:0]  rsv;
    logic [CODE_BITS-1:0] codes [2];
    for (int i = 0; i < 2; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0)     lens[i] = '0;
      else if (r == 1) lens[i] = '1;
      else if (r < 7)  lens[i] = LEN_BITS'($urandom_range(2, 4));
      else             lens[i] = LEN_BITS'($urandom_range(0, 15));
      r = $urandom_range(0, 4);
      if (r == 0)      codes[i] = '0;
      else if (r == 1) codes[i] = '1;
      else             codes[i] = CODE_BITS'($urandom_range(0, 4095));
    end
    r = $urandom_range(0, 9);
    case (r)
      0:       lit = 9'd1;
      1:       lit = 9'd256;
      2:       lit = LIT_BITS'($urandom_range(257, 511));
      3:       lit = '0;
      default: lit = LIT_BITS'($urandom_range(1, 8));
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0:       rsv = '0;
      1:       rsv = 5'd16;
      2:       rsv = '1;
      default: rsv = RSV_BITS'($urandom_range(0, 4));
    endcase
    set_config(lens[0], lens[1], lit, rsv, codes[0], codes[1]);
  endtask

  // Mostly strings over a tiny alphabet so the trie gets hits, with random bytes
  // and finishes cut into the middle of strings as noise.
  task automatic random_stream(input int n);
    int                   r;
    logic [BYTE_BITS-1:0] alpha [4];
    foreach (alpha[i]) alpha[i] = BYTE_BITS'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)       send_item(KIND_FINISH, BYTE_BITS'($urandom_range(0, 255)));
      else if (r < 85) send_item(KIND_DATA, alpha[$urandom_range(0, 3)]);
      else             send_item(KIND_DATA, BYTE_BITS'($urandom_range(0, 255)));
    end
    send_item(KIND_FINISH, BYTE_BITS'($urandom_range(0, 255)));
  endtask

  // Receiver: random stall pattern, plus one long hold-off on request.
  initial begin
    int n_free;
    int n_stall;
    result_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        if (calm)                          n_free = 1;
        else if ($urandom_range(0, 9) == 0) n_free = $urandom_range(20, 60);
        else                               n_free = $urandom_range(1, 6);
        result_stall <= 1'b0;
        repeat (n_free) @(posedge clk);
        n_stall = pick_gap();
        if (n_stall > 0) begin
          result_stall <= 1'b1;
          repeat (n_stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: finish with no prefix still sends the end code; repeated
    // zeros walk the trie; finish carries a stray data byte.
    send_item(KIND_FINISH, 8'h3c);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_FINISH, 8'ha5);
    settle();

    // Initial width below range, max above it, literal count of one, no end code: the first finish
    // has nothing pending and gives no bytes; byte codes exceed the 2-bit width.
    set_config(4'd0, 4'd15, 9'd1, 5'd0, 12'hfff, 12'h000);
    send_item(KIND_FINISH, 8'hff);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_DATA, 8'h12);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_DATA, 8'h12);
    send_item(KIND_FINISH, 8'h00);
    settle();

    // Max width clamped to 2: the dictionary fills at once and the reset code goes out.
    set_config(4'd1, 4'd1, 9'd4, 5'd0, 12'hfff, 12'hfff);
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_DATA, 8'h03);
    send_item(KIND_DATA, 8'h02);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h03);
    send_item(KIND_FINISH, 8'h80);
    settle();

    // Initial width above range, max below it, 16 reserved codes, zero reset code.
    set_config(4'd15, 4'd0, 9'd256, 5'd16, 12'h000, 12'h801);
    send_item(KIND_FINISH, 8'h7f);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_FINISH, 8'h01);
    settle();

    // Random phases; two run without gaps, and one of those holds off the
    // receiver so the output fills and the input stalls.
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3 || ph == 6);
      random_config();
      if (ph == 3) hold_req = 1'b1;
      random_stream(16);
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: the limit must cover the trie sweep after reset, which visits every trie entry.
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
